// ----- design/semv_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// semv_pkg: shared types and constants of the semantic version validator
// Character codes, section and status codes, field flags and item structs.
// ----------------------------------------------------------------------------
package semv_pkg;

    localparam int MAX_LENGTH = 256;
    localparam int LEN_W      = $clog2(MAX_LENGTH + 2);
    localparam int NUM_W      = 64;
    localparam int STATUS_W   = 4;
    localparam int CHAR_W     = 8;

    localparam logic CMD_CHAR = 1'b0;
    localparam logic CMD_END  = 1'b1;

    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_DASH  = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_UP_A  = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UP_Z  = 8'h5A;
    localparam logic [CHAR_W-1:0] CH_LOW_A = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LOW_Z = 8'h7A;

    localparam logic [1:0] SEC_CORE  = 2'd0;
    localparam logic [1:0] SEC_PRE   = 2'd1;
    localparam logic [1:0] SEC_BUILD = 2'd2;

    localparam logic [1:0] LAST_FIELD = 2'd3;
    localparam logic [1:0] PATCH_IDX  = 2'd2;

    localparam logic [STATUS_W-1:0] ST_VALID        = 4'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY        = 4'd1;
    localparam logic [STATUS_W-1:0] ST_TOO_LONG     = 4'd2;
    localparam logic [STATUS_W-1:0] ST_MISSING_CORE = 4'd3;
    localparam logic [STATUS_W-1:0] ST_BAD_NUMBER   = 4'd4;
    localparam logic [STATUS_W-1:0] ST_LEADING_ZERO = 4'd5;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW     = 4'd6;
    localparam logic [STATUS_W-1:0] ST_PRE_EMPTY    = 4'd7;
    localparam logic [STATUS_W-1:0] ST_PRE_BAD      = 4'd8;
    localparam logic [STATUS_W-1:0] ST_BUILD_EMPTY  = 4'd9;
    localparam logic [STATUS_W-1:0] ST_BUILD_BAD    = 4'd10;

    typedef struct packed {
        logic extra;
        logic multi;
        logic zero;
        logic nondig;
        logic empty;
    } t_flags;

    localparam t_flags FLAGS_CLEAR = 5'b00001;

    typedef struct packed {
        logic              command;
        logic [CHAR_W-1:0] character;
    } t_item;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [NUM_W-1:0]    major;
        logic [NUM_W-1:0]    minor;
        logic [NUM_W-1:0]    patch;
        logic                has_prerelease;
        logic                has_build;
    } t_result;

endpackage

// ----- design/semv_in_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// semv_in_if: text item channel
// Valid/ready channel carrying one command and one character per item.
// ----------------------------------------------------------------------------
interface semv_in_if;
    import semv_pkg::*;

    logic              valid;
    logic              ready;
    logic              command;
    logic [CHAR_W-1:0] character;

    modport source (output valid, output command, output character, input ready);
    modport sink   (input valid, input command, input character, output ready);
endinterface

// ----- design/semv_out_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// semv_out_if: result item channel
// Valid/ready channel carrying status, core numbers and presence flags.
// ----------------------------------------------------------------------------
interface semv_out_if;
    import semv_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [NUM_W-1:0]    major;
    logic [NUM_W-1:0]    minor;
    logic [NUM_W-1:0]    patch;
    logic                has_prerelease;
    logic                has_build;

    modport source (output valid, output status, output major, output minor, output patch,
                    output has_prerelease, output has_build, input ready);
    modport sink   (input valid, input status, input major, input minor, input patch,
                    input has_prerelease, input has_build, output ready);
endinterface

// ----- design/semv_in_stage.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// semv_in_stage: input register
// Holds one accepted text item until the parser consumes it.
// ----------------------------------------------------------------------------
module semv_in_stage (
    input  logic            i_clk,
    input  logic            i_rst_n,
    semv_in_if.sink         i_in,
    input  logic            i_take,
    output logic            o_valid,
    output semv_pkg::t_item o_item
);
    import semv_pkg::*;

    logic  r_valid;
    t_item r_item;

    assign i_in.ready = !r_valid || i_take;
    assign o_valid    = r_valid;
    assign o_item     = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_item <= '{command: i_in.command, character: i_in.character};
        end
    end
endmodule

// ----- design/semv_parser.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// semv_parser: version text parser
// Per-item state update (field flags, multiply-by-ten accumulate, error
// capture) and the result computed when an end item is consumed.
// ----------------------------------------------------------------------------
module semv_parser (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  semv_pkg::t_item   i_item,
    output logic              o_result_valid,
    output semv_pkg::t_result o_result
);
    import semv_pkg::*;

    localparam int PROD_W = NUM_W + 4;

    logic [LEN_W-1:0]    r_len,        n_len;
    logic [1:0]          r_section,    n_section;
    logic [1:0]          r_idx,        n_idx;
    logic [NUM_W-1:0]    r_acc,        n_acc;
    logic [NUM_W-1:0]    r_major,      n_major;
    logic [NUM_W-1:0]    r_minor,      n_minor;
    t_flags              r_flags,      n_flags;
    logic [STATUS_W-1:0] r_core_err,   n_core_err;
    logic [STATUS_W-1:0] r_tail_err,   n_tail_err;
    logic                r_seen_pre,   n_seen_pre;
    logic                r_seen_build, n_seen_build;

    logic [CHAR_W-1:0]   c;
    logic                c_is_digit;
    logic                c_is_ident;
    logic [PROD_W-1:0]   acc_wide;
    logic [PROD_W-1:0]   prod;
    t_flags              note_flags;
    logic [NUM_W-1:0]    note_acc;
    logic [STATUS_W-1:0] core_code;
    logic [STATUS_W-1:0] tail_code;
    logic [STATUS_W-1:0] closed_core_err;
    logic [STATUS_W-1:0] closed_tail_err;
    logic                store_major;
    logic                store_minor;
    logic [STATUS_W-1:0] fin_core_err;
    logic [STATUS_W-1:0] fin_tail_err;
    logic [STATUS_W-1:0] status;
    logic                is_end;

    assign c          = i_item.character;
    assign is_end     = i_item.command == CMD_END;
    assign c_is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
    assign c_is_ident = c_is_digit || ((c >= CH_UP_A) && (c <= CH_UP_Z))
                        || ((c >= CH_LOW_A) && (c <= CH_LOW_Z)) || (c == CH_DASH);
    // acc * 10 + digit as two shifts and adds
    assign acc_wide   = {4'b0, r_acc};
    assign prod       = (acc_wide << 3) + (acc_wide << 1)
                        + {{(PROD_W-CHAR_W){1'b0}}, c - CH_ZERO};

    always_comb begin
        note_flags = r_flags;
        note_acc   = r_acc;
        if (r_flags.empty) begin
            note_flags.empty = 1'b0;
            note_flags.zero  = r_flags.zero | (c == CH_ZERO);
        end else begin
            note_flags.multi = 1'b1;
        end
        if (!c_is_digit) begin
            note_flags.nondig = 1'b1;
        end
        if (r_section == SEC_CORE) begin
            if (r_idx != LAST_FIELD && c_is_digit && !r_flags.extra) begin
                if (|prod[PROD_W-1:NUM_W]) begin
                    note_flags.extra = 1'b1;
                end else begin
                    note_acc = prod[NUM_W-1:0];
                end
            end
        end else if (!c_is_ident) begin
            note_flags.extra = 1'b1;
        end
    end

    always_comb begin
        priority if (r_flags.empty) begin
            core_code = ST_MISSING_CORE;
        end else if (r_flags.nondig) begin
            core_code = ST_BAD_NUMBER;
        end else if (r_flags.zero && r_flags.multi) begin
            core_code = ST_LEADING_ZERO;
        end else if (r_flags.extra) begin
            core_code = ST_OVERFLOW;
        end else begin
            core_code = ST_VALID;
        end
    end

    always_comb begin
        if (r_section == SEC_PRE) begin
            priority if (r_flags.empty) begin
                tail_code = ST_PRE_EMPTY;
            end else if (r_flags.extra) begin
                tail_code = ST_PRE_BAD;
            end else if (!r_flags.nondig && r_flags.zero && r_flags.multi) begin
                tail_code = ST_LEADING_ZERO;
            end else begin
                tail_code = ST_VALID;
            end
        end else begin
            priority if (r_flags.empty) begin
                tail_code = ST_BUILD_EMPTY;
            end else if (r_flags.extra) begin
                tail_code = ST_BUILD_BAD;
            end else begin
                tail_code = ST_VALID;
            end
        end
    end

    assign closed_core_err = (r_idx != LAST_FIELD && core_code != ST_VALID
                              && r_core_err == ST_VALID) ? core_code : r_core_err;
    assign closed_tail_err = (tail_code != ST_VALID && r_tail_err == ST_VALID)
                             ? tail_code : r_tail_err;
    assign store_major     = (r_idx == 2'd0) && (core_code == ST_VALID);
    assign store_minor     = (r_idx == 2'd1) && (core_code == ST_VALID);

    always_comb begin
        n_len        = r_len;
        n_section    = r_section;
        n_idx        = r_idx;
        n_acc        = r_acc;
        n_major      = r_major;
        n_minor      = r_minor;
        n_flags      = r_flags;
        n_core_err   = r_core_err;
        n_tail_err   = r_tail_err;
        n_seen_pre   = r_seen_pre;
        n_seen_build = r_seen_build;
        if (i_step) begin
            if (is_end) begin
                n_len        = '0;
                n_section    = SEC_CORE;
                n_idx        = 2'd0;
                n_acc        = '0;
                n_major      = '0;
                n_minor      = '0;
                n_flags      = FLAGS_CLEAR;
                n_core_err   = ST_VALID;
                n_tail_err   = ST_VALID;
                n_seen_pre   = 1'b0;
                n_seen_build = 1'b0;
            end else begin
                if (r_len <= LEN_W'(MAX_LENGTH)) begin
                    n_len = r_len + LEN_W'(1);
                end
                if (r_section == SEC_CORE) begin
                    if (c == CH_DOT || c == CH_DASH || c == CH_PLUS) begin
                        n_core_err = closed_core_err;
                        n_flags    = FLAGS_CLEAR;
                        if (store_major) begin
                            n_major = r_acc;
                        end
                        if (store_minor) begin
                            n_minor = r_acc;
                        end
                        if (c == CH_DOT) begin
                            n_acc = '0;
                            if (r_idx != LAST_FIELD) begin
                                n_idx = r_idx + 2'd1;
                            end
                        end else if (c == CH_PLUS) begin
                            n_section    = SEC_BUILD;
                            n_seen_build = 1'b1;
                        end else begin
                            n_section  = SEC_PRE;
                            n_seen_pre = 1'b1;
                        end
                    end else begin
                        n_flags = note_flags;
                        n_acc   = note_acc;
                    end
                end else if (c == CH_DOT) begin
                    n_tail_err = closed_tail_err;
                    n_flags    = FLAGS_CLEAR;
                end else if (c == CH_PLUS && r_section == SEC_PRE) begin
                    n_tail_err   = closed_tail_err;
                    n_flags      = FLAGS_CLEAR;
                    n_section    = SEC_BUILD;
                    n_seen_build = 1'b1;
                end else begin
                    n_flags = note_flags;
                end
            end
        end
    end

    assign fin_core_err = (r_section == SEC_CORE) ? closed_core_err : r_core_err;
    assign fin_tail_err = (r_section == SEC_CORE) ? r_tail_err : closed_tail_err;

    always_comb begin
        priority if (r_len == '0) begin
            status = ST_EMPTY;
        end else if (r_len > LEN_W'(MAX_LENGTH)) begin
            status = ST_TOO_LONG;
        end else if (r_idx != PATCH_IDX) begin
            status = ST_MISSING_CORE;
        end else if (fin_core_err != ST_VALID) begin
            status = fin_core_err;
        end else begin
            status = fin_tail_err;
        end
    end

    assign o_result_valid          = i_step && is_end;
    assign o_result.status         = status;
    assign o_result.major          = (status == ST_VALID) ? r_major : '0;
    assign o_result.minor          = (status == ST_VALID) ? r_minor : '0;
    assign o_result.patch          = (status == ST_VALID) ? r_acc : '0;
    assign o_result.has_prerelease = r_seen_pre;
    assign o_result.has_build      = r_seen_build;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len        <= '0;
            r_section    <= SEC_CORE;
            r_idx        <= 2'd0;
            r_acc        <= '0;
            r_major      <= '0;
            r_minor      <= '0;
            r_flags      <= FLAGS_CLEAR;
            r_core_err   <= ST_VALID;
            r_tail_err   <= ST_VALID;
            r_seen_pre   <= 1'b0;
            r_seen_build <= 1'b0;
        end else begin
            r_len        <= n_len;
            r_section    <= n_section;
            r_idx        <= n_idx;
            r_acc        <= n_acc;
            r_major      <= n_major;
            r_minor      <= n_minor;
            r_flags      <= n_flags;
            r_core_err   <= n_core_err;
            r_tail_err   <= n_tail_err;
            r_seen_pre   <= n_seen_pre;
            r_seen_build <= n_seen_build;
        end
    end

    a_zero_unless_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && o_result.status != ST_VALID
        |-> o_result.major == '0 && o_result.minor == '0 && o_result.patch == '0)
        else $error("core numbers not zero on a failing result");

    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |=> r_len == '0 && r_section == SEC_CORE && r_idx == 2'd0
                           && r_core_err == ST_VALID && r_tail_err == ST_VALID)
        else $error("parser state not cleared after end item");

    a_len_saturates: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= LEN_W'(MAX_LENGTH + 1))
        else $error("text length counter beyond saturation");

    a_empty_no_parts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && o_result.status == ST_EMPTY
        |-> !o_result.has_prerelease && !o_result.has_build)
        else $error("empty text reports a prerelease or build part");

    a_build_seen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_section == SEC_BUILD |-> r_seen_build)
        else $error("build section without build flag");
endmodule

// ----- design/semv_out_stage.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// semv_out_stage: result register
// Holds one result item until the sink takes it.
// ----------------------------------------------------------------------------
module semv_out_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  semv_pkg::t_result i_result,
    output logic              o_free,
    semv_out_if.source        o_out
);
    import semv_pkg::*;

    logic    r_valid;
    t_result r_result;

    assign o_free               = !r_valid || o_out.ready;
    assign o_out.valid          = r_valid;
    assign o_out.status         = r_result.status;
    assign o_out.major          = r_result.major;
    assign o_out.minor          = r_result.minor;
    assign o_out.patch          = r_result.patch;
    assign o_out.has_prerelease = r_result.has_prerelease;
    assign o_out.has_build      = r_result.has_build;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end
endmodule

// ----- design/semantic_version_validator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// semantic_version_validator: streaming semantic version checker
// The end item passes the input register and the parser; its result is then held in the result register.
// Throughput: one item per cycle unless an end item stalls; character items never wait on the output.
// An end item stalls only while the result register still holds an untaken item.
// Reset (synchronous, active low) empties both registers and clears the parser.
// ----------------------------------------------------------------------------
module semantic_version_validator (
    input  logic       i_clk,
    input  logic       i_rst_n,
    semv_in_if.sink    i_in,
    semv_out_if.source o_out
);
    import semv_pkg::*;

    logic    in_valid;
    t_item   in_item;
    logic    take;
    logic    out_free;
    logic    result_valid;
    t_result result;

    assign take = in_valid && (in_item.command == CMD_CHAR || out_free);

    semv_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_take  (take),
        .o_valid (in_valid),
        .o_item  (in_item)
    );

    semv_parser u_parser (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_step         (take),
        .i_item         (in_item),
        .o_result_valid (result_valid),
        .o_result       (result)
    );

    semv_out_stage u_out_stage (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (result_valid),
        .i_result (result),
        .o_free   (out_free),
        .o_out    (o_out)
    );
endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for semantic_version_validator
// Streams version texts one character per item, each closed by an end item.
// A built-in parser model predicts the result of every text. Results are
// compared field by field in order. Stimulus runs directed texts, a long
// output hold that backs up the input, then random texts under four idling
// phases.
// ----------------------------------------------------------------------------
module testbench;
    import semv_pkg::*;

    localparam logic [1:0] MAJOR_IDX   = 2'd0;
    localparam logic [1:0] MINOR_IDX   = 2'd1;
    localparam int         HOLD_CYCLES = 150;
    localparam int         PHASE_ITEMS = 20;

    logic i_clk;
    logic i_rst_n;

    semv_in_if  text_ch ();
    semv_out_if result_ch ();

    semantic_version_validator u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (text_ch.sink),
        .o_out   (result_ch.source)
    );

    t_item       pending_items[$];
    t_result     expected_results[$];
    logic [7:0]  text_buf[$];
    int          queued_items;
    int          mismatches;
    int          send_idle_pct;
    int          recv_stall_pct;
    logic        text_taken;
    logic        hold_req;
    int          hold_left;
    string       ident_chars = "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz-";
    string       noise_chars = "019.-+aZ";

    // parser model state
    int unsigned text_len;
    logic [1:0]  sec;
    logic [1:0]  field_idx;
    logic [63:0] acc;
    logic [63:0] major_q;
    logic [63:0] minor_q;
    t_flags      flags;
    logic [3:0]  core_err;
    logic [3:0]  tail_err;
    logic        saw_pre;
    logic        saw_build;

    initial begin
        i_clk = 1'b0;
    end

    always #1 i_clk = ~i_clk;

    function automatic logic is_decimal(logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function automatic logic is_ident(logic [7:0] c);
        return is_decimal(c) || (c >= CH_UP_A && c <= CH_UP_Z) ||
               (c >= CH_LOW_A && c <= CH_LOW_Z) || c == CH_DASH;
    endfunction

    function automatic void clear_parser();
        text_len  = 0;
        sec       = SEC_CORE;
        field_idx = MAJOR_IDX;
        acc       = '0;
        major_q   = '0;
        minor_q   = '0;
        flags     = FLAGS_CLEAR;
        core_err  = ST_VALID;
        tail_err  = ST_VALID;
        saw_pre   = 1'b0;
        saw_build = 1'b0;
    endfunction

    function automatic void close_number();
        logic [3:0] err;
        err = ST_VALID;
        if (field_idx == LAST_FIELD) begin
            flags = FLAGS_CLEAR;
            return;
        end
        if (flags.empty) err = ST_MISSING_CORE;
        else if (flags.nondig) err = ST_BAD_NUMBER;
        else if (flags.zero && flags.multi) err = ST_LEADING_ZERO;
        else if (flags.extra) err = ST_OVERFLOW;
        if (err != ST_VALID) begin
            if (core_err == ST_VALID) core_err = err;
        end else if (field_idx == MAJOR_IDX) begin
            major_q = acc;
        end else if (field_idx == MINOR_IDX) begin
            minor_q = acc;
        end
        flags = FLAGS_CLEAR;
    endfunction

    function automatic void close_ident();
        logic [3:0] err;
        err = ST_VALID;
        if (sec == SEC_PRE) begin
            if (flags.empty) err = ST_PRE_EMPTY;
            else if (flags.extra) err = ST_PRE_BAD;
            else if (!flags.nondig && flags.zero && flags.multi) err = ST_LEADING_ZERO;
        end else begin
            if (flags.empty) err = ST_BUILD_EMPTY;
            else if (flags.extra) err = ST_BUILD_BAD;
        end
        if (err != ST_VALID && tail_err == ST_VALID) tail_err = err;
        flags = FLAGS_CLEAR;
    endfunction

    function automatic void note_char(logic [7:0] c);
        logic [63:0] d;
        d = {56'd0, c - CH_ZERO};
        if (flags.empty) begin
            flags.empty = 1'b0;
            if (c == CH_ZERO) flags.zero = 1'b1;
        end else begin
            flags.multi = 1'b1;
        end
        if (!is_decimal(c)) flags.nondig = 1'b1;
        if (sec == SEC_CORE) begin
            if (field_idx != LAST_FIELD && is_decimal(c) && !flags.extra) begin
                if (acc > (64'hFFFF_FFFF_FFFF_FFFF - d) / 64'd10) flags.extra = 1'b1;
                else acc = acc * 64'd10 + d;
            end
        end else if (!is_ident(c)) begin
            flags.extra = 1'b1;
        end
    endfunction

    function automatic void parse_char(logic [7:0] c);
        if (text_len <= MAX_LENGTH) text_len++;
        if (sec == SEC_CORE) begin
            if (c == CH_DOT) begin
                close_number();
                acc = '0;
                if (field_idx != LAST_FIELD) field_idx++;
            end else if (c == CH_DASH || c == CH_PLUS) begin
                close_number();
                if (c == CH_PLUS) begin
                    sec       = SEC_BUILD;
                    saw_build = 1'b1;
                end else begin
                    sec     = SEC_PRE;
                    saw_pre = 1'b1;
                end
            end else begin
                note_char(c);
            end
        end else if (c == CH_DOT) begin
            close_ident();
        end else if (c == CH_PLUS && sec == SEC_PRE) begin
            close_ident();
            sec       = SEC_BUILD;
            saw_build = 1'b1;
        end else begin
            note_char(c);
        end
    endfunction

    function automatic t_result finish_text();
        t_result    r;
        logic [3:0] st;
        if (sec == SEC_CORE) close_number();
        else close_ident();
        if (text_len == 0) st = ST_EMPTY;
        else if (text_len > MAX_LENGTH) st = ST_TOO_LONG;
        else if (field_idx != PATCH_IDX) st = ST_MISSING_CORE;
        else if (core_err != ST_VALID) st = core_err;
        else st = tail_err;
        r.status         = st;
        r.major          = (st == ST_VALID) ? major_q : '0;
        r.minor          = (st == ST_VALID) ? minor_q : '0;
        r.patch          = (st == ST_VALID) ? acc : '0;
        r.has_prerelease = saw_pre;
        r.has_build      = saw_build;
        clear_parser();
        return r;
    endfunction

    function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    // ------------------------------------------------------------------
    // text builders
    // ------------------------------------------------------------------
    task automatic put_byte(logic [7:0] b);
        text_buf = {text_buf, b};
    endtask

    task automatic put_str(string s);
        for (int i = 0; i < s.len(); i++) text_buf = {text_buf, s[i]};
    endtask

    function automatic string rand_number();
        logic [63:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(9))
            0, 1, 2: return $sformatf("%0d", $urandom_range(20));
            3:       return $sformatf("%0d", $urandom_range(99999));
            4, 5:    return $sformatf("%0d", v >> $urandom_range(63));
            6:       return "18446744073709551615";
            7:       return $sformatf("1844674407370955161%0d", $urandom_range(5, 9));
            8:       return $sformatf("0%0d", $urandom_range(99));
            default: return "0";
        endcase
    endfunction

    task automatic put_ident();
        int n;
        case ($urandom_range(5))
            0: put_str($sformatf("%0d", $urandom_range(999)));
            1: put_str($sformatf("0%0d", $urandom_range(99)));
            default: begin
                n = $urandom_range(1, 6);
                repeat (n) put_byte(ident_chars[$urandom_range(ident_chars.len() - 1)]);
            end
        endcase
    endtask

    task automatic put_idents();
        int n;
        n = $urandom_range(1, 3);
        for (int i = 0; i < n; i++) begin
            if (i != 0) put_byte(CH_DOT);
            put_ident();
        end
    endtask

    task automatic put_version();
        put_str(rand_number());
        put_byte(CH_DOT);
        put_str(rand_number());
        put_byte(CH_DOT);
        put_str(rand_number());
        if ($urandom_range(1) != 0) begin
            put_byte(CH_DASH);
            put_idents();
        end
        if ($urandom_range(2) == 0) begin
            put_byte(CH_PLUS);
            put_idents();
        end
    endtask

    task automatic pad_build(int len);
        put_str("1.2.3+");
        while (text_buf.size() < len) put_byte(CH_LOW_A + 8'($urandom_range(25)));
    endtask

    task automatic mutate_text();
        int         pos;
        logic [7:0] b;
        if (text_buf.size() == 0) return;
        pos = $urandom_range(text_buf.size() - 1);
        case ($urandom_range(2))
            0: b = CH_DOT;
            1: b = CH_DASH;
            default: b = CH_PLUS;
        endcase
        case ($urandom_range(2))
            0: text_buf[pos] = 8'($urandom);
            1: text_buf.insert(pos, b);
            default: text_buf.delete(pos);
        endcase
    endtask

    task automatic queue_text();
        t_item it;
        foreach (text_buf[i]) begin
            it.command   = CMD_CHAR;
            it.character = text_buf[i];
            pending_items = {pending_items, it};
        end
        it.command   = CMD_END;
        it.character = 8'($urandom);
        pending_items = {pending_items, it};
        queued_items += text_buf.size() + 1;
        text_buf.delete();
    endtask

    task automatic random_text();
        int r;
        int n;
        r = $urandom_range(99);
        if (r < 10) begin
            n = $urandom_range(10);
            repeat (n) begin
                if ($urandom_range(1) != 0) put_byte(8'($urandom));
                else put_byte(noise_chars[$urandom_range(noise_chars.len() - 1)]);
            end
        end else begin
            put_version();
            if (r < 35) repeat ($urandom_range(1, 2)) mutate_text();
        end
        queue_text();
    endtask

    task automatic drain();
        while (pending_items.size() != 0 || text_ch.valid || expected_results.size() != 0)
            @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // driver, receiver, hold counter, monitor
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin : driver
        t_item it;
        if (!i_rst_n) begin
            text_ch.valid <= 1'b0;
        end else if (!text_ch.valid || text_taken) begin
            if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                it = pending_items.pop_front();
                text_ch.valid     <= 1'b1;
                text_ch.command   <= it.command;
                text_ch.character <= it.character;
            end else begin
                text_ch.valid     <= 1'b0;
                text_ch.command   <= 1'($urandom);
                text_ch.character <= 8'($urandom);
            end
        end
    end

    always @(negedge i_clk) begin : receiver
        if (!i_rst_n) result_ch.ready <= 1'b0;
        else result_ch.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
    end

    always @(negedge i_clk) begin : hold_counter
        if (hold_req) hold_left <= HOLD_CYCLES;
        else if (hold_left != 0) hold_left <= hold_left - 1;
    end

    always @(posedge i_clk) begin : monitor
        t_result want;
        if (!i_rst_n) begin
            text_taken <= 1'b0;
            clear_parser();
        end else begin
            text_taken <= text_ch.valid && text_ch.ready;
            if (result_ch.valid && result_ch.ready) begin
                if (expected_results.size() == 0) begin
                    $error("result item with no expected result pending");
                    mismatches++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("status", want.status, result_ch.status);
                    check_field("major", want.major, result_ch.major);
                    check_field("minor", want.minor, result_ch.minor);
                    check_field("patch", want.patch, result_ch.patch);
                    check_field("has_prerelease", want.has_prerelease,
                                result_ch.has_prerelease);
                    check_field("has_build", want.has_build, result_ch.has_build);
                end
            end
            if (text_ch.valid && text_ch.ready) begin
                if (text_ch.command == CMD_END) begin
                    expected_results = {expected_results, finish_text()};
                end else begin
                    parse_char(text_ch.character);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    initial begin : stimulus
        int phase_start;
        text_ch.valid     = 1'b0;
        text_ch.command   = CMD_CHAR;
        text_ch.character = '0;
        result_ch.ready   = 1'b0;
        hold_req          = 1'b0;
        hold_left         = 0;
        text_taken        = 1'b0;
        queued_items      = 0;
        mismatches        = 0;
        send_idle_pct     = 0;
        recv_stall_pct    = 0;
        i_rst_n           = 1'b0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        queue_text();
        put_str("1.2.3");                   queue_text();
        put_str("1.2.3-rc.1+build.5");      queue_text();
        put_str("18446744073709551615.0.1"); queue_text();
        put_str("18446744073709551616.0.0"); queue_text();
        put_str("01.2.3");                  queue_text();
        put_str("1.2");                     queue_text();
        put_str("1.2.3.4");                 queue_text();
        put_str("1..3");                    queue_text();
        put_str("1.x.3");                   queue_text();
        put_str("1.2.");  put_byte(8'hFF);  queue_text();
        put_str("1.2.3-01");                queue_text();
        put_str("1.2.3-");                  queue_text();
        put_str("1.2.3-a..b");              queue_text();
        put_str("1.2.3-a"); put_byte(8'h80); queue_text();
        put_str("1.2.3+");                  queue_text();
        put_str("1.2.3+a+b");               queue_text();
        put_str("1.2.3+"); put_byte(8'h00); queue_text();
        pad_build(MAX_LENGTH + 1);          queue_text();
        drain();

        // output held off while short texts keep arriving
        repeat (6) begin
            put_str($sformatf("%0d.%0d.%0d", $urandom_range(9), $urandom_range(99),
                              $urandom_range(999)));
            queue_text();
        end
        @(posedge i_clk);
        hold_req = 1'b1;
        @(posedge i_clk);
        hold_req = 1'b0;
        drain();

        for (int p = 0; p < 4; p++) begin
            case (p)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 73; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 73; end
                default: begin send_idle_pct = 29; recv_stall_pct = 29; end
            endcase
            phase_start = queued_items;
            while (queued_items - phase_start < PHASE_ITEMS) random_text();
            drain();
        end

        repeat (10) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin : watchdog
        #1000000;
        $display("tb: failure");
        $finish;
    end

endmodule

// ----- filelist.f -----
design/semv_pkg.sv
design/semv_in_if.sv
design/semv_out_if.sv
design/semv_in_stage.sv
design/semv_parser.sv
design/semv_out_stage.sv
design/semantic_version_validator.sv
tb/testbench.sv
